// ===== sv/jpp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jpp_pkg;

    // Field and state widths
    localparam int LVL_W     = 5;
    localparam int CNT_W     = 4;
    localparam int POS_W     = CNT_W + 1;
    localparam int MODE_W    = 2;
    localparam int MAX_DEPTH_DEFAULT = 12;

    // Plan slots: flushed bracket, current byte, bracket flushed at end of text
    localparam int NUM_SLOTS = 6;
    localparam int IDX_W     = $clog2(NUM_SLOTS);
    localparam int SLOT_A0   = 0;
    localparam int SLOT_A1   = 1;
    localparam int SLOT_B0   = 2;
    localparam int SLOT_B1   = 3;
    localparam int SLOT_C0   = 4;
    localparam int SLOT_C1   = 5;

    // Format modes (code 3 behaves as compact)
    localparam logic [MODE_W-1:0] MODE_PASS    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COMPACT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PRETTY  = 2'd2;

    // Characters
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_word_t;

    // One plan slot: a single byte, or CR LF plus 2*cnt spaces
    typedef struct packed {
        logic             vld;
        logic             is_nl;
        logic [7:0]       data;
        logic [CNT_W-1:0] cnt;
    } slot_t;

    typedef slot_t [NUM_SLOTS-1:0] slot_vec_t;

    typedef struct packed {
        logic      vld;
        slot_vec_t slots;
    } plan_t;

    function automatic slot_t byte_slot(input logic [7:0] b);
        slot_t s;
        s.vld   = 1'b1;
        s.is_nl = 1'b0;
        s.data  = b;
        s.cnt   = '0;
        return s;
    endfunction

    // Newline slot; negative levels print no spaces
    function automatic slot_t nl_slot(input logic signed [LVL_W-1:0] lvl);
        slot_t s;
        s.vld   = 1'b1;
        s.is_nl = 1'b1;
        s.data  = CH_CR;
        s.cnt   = (lvl > 0) ? lvl[CNT_W-1:0] : '0;
        return s;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    // Lowest valid slot above cur; MSB flags a hit
    function automatic logic [IDX_W:0] next_slot(input slot_vec_t slots,
                                                 input logic [IDX_W-1:0] cur,
                                                 input logic from_start);
        logic [IDX_W:0] res;
        res = '0;
        for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
            if (slots[j].vld && (from_start || (j > int'(cur)))) begin
                res = {1'b1, IDX_W'(j)};
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/json_pretty_printer_top.sv =====
// With the output idle, a word accepted into the input register is decoded into a plan that
// loads the output sequencer, which then puts the word's first output byte on dst.
// Throughput: one output byte per cycle while dst_stall is low, set by the single-byte output
// sequencer walking the word's plan.
// Words that produce no output are absorbed at one per cycle.
// Reset (rst_n low, asynchronous) clears mode to passthrough and all formatter state.
`timescale 1ns / 1ps
`default_nettype none

module json_pretty_printer_top
    import jpp_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEFAULT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [MODE_W-1:0] cfg_wdata,
    input  wire logic              src_valid,
    output      logic              src_stall,
    input  wire in_word_t          src_word,
    output      logic              dst_valid,
    input  wire logic              dst_stall,
    output      out_word_t         dst_word
);

    logic [MODE_W-1:0] mode_reg;
    plan_t             plan;
    logic              plan_ready;

    // Format mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_PASS;
        else if (cfg_we)
            mode_reg <= cfg_wdata;
    end

    jpp_plan #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_plan (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_word   (src_word),
        .plan       (plan),
        .plan_ready (plan_ready)
    );

    jpp_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .plan       (plan),
        .plan_ready (plan_ready),
        .dst_valid  (dst_valid),
        .dst_stall  (dst_stall),
        .dst_word   (dst_word)
    );

endmodule

`default_nettype wire

// ===== sv/jpp_plan.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jpp_plan
    import jpp_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEFAULT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [MODE_W-1:0] mode,
    input  wire logic              src_valid,
    output      logic              src_stall,
    input  wire in_word_t          src_word,
    output      plan_t             plan,
    input  wire logic              plan_ready
);

    localparam logic signed [LVL_W-1:0] MAX_LVL = LVL_W'(MAX_DEPTH);
    localparam logic signed [LVL_W-1:0] MIN_LVL = -MAX_LVL;

    logic                    in_full_reg;
    in_word_t                in_word_reg;
    logic                    inside_reg, inside_next;
    logic                    esc_reg, esc_next;
    logic signed [LVL_W-1:0] lvl_reg, lvl_next;
    logic                    held_reg, held_next;
    logic                    sq_reg, sq_next;

    slot_vec_t               slots;
    logic                    has_bytes;
    logic                    consume;

    // Decode the held word into a plan and the next formatter state
    always_comb
    begin
        logic [7:0]              c;
        logic                    eot;
        logic [7:0]              open_b;
        logic [7:0]              close_b;
        logic signed [LVL_W-1:0] lvl;

        c       = in_word_reg.in_byte;
        eot     = in_word_reg.end_of_text;
        open_b  = sq_reg ? CH_LBRACK : CH_LBRACE;
        close_b = sq_reg ? CH_RBRACK : CH_RBRACE;
        lvl     = lvl_reg;

        slots       = '0;
        inside_next = inside_reg;
        esc_next    = esc_reg;
        held_next   = held_reg;
        sq_next     = sq_reg;

        if (mode == MODE_PRETTY)
        begin
            if (inside_reg)
            begin
                slots[SLOT_B0] = byte_slot(c);
                if (esc_reg)
                    esc_next = 1'b0;
                else if (c == CH_BSLASH)
                    esc_next = 1'b1;
                else if (c == CH_QUOTE)
                    inside_next = 1'b0;
            end
            else if (!is_ws(c))
            begin
                if (held_reg && (c == close_b))
                begin
                    // empty pair stays on one line
                    slots[SLOT_A0] = byte_slot(open_b);
                    slots[SLOT_B0] = byte_slot(c);
                    held_next      = 1'b0;
                end
                else
                begin
                    if (held_reg)
                    begin
                        slots[SLOT_A0] = byte_slot(open_b);
                        if (lvl < MAX_LVL)
                            lvl = lvl + LVL_W'(1);
                        slots[SLOT_A1] = nl_slot(lvl);
                        held_next      = 1'b0;
                    end
                    case (c)
                        CH_QUOTE:
                        begin
                            inside_next    = 1'b1;
                            slots[SLOT_B0] = byte_slot(c);
                        end
                        CH_LBRACE, CH_LBRACK:
                        begin
                            held_next = 1'b1;
                            sq_next   = (c == CH_LBRACK);
                        end
                        CH_RBRACE, CH_RBRACK:
                        begin
                            if (lvl > MIN_LVL)
                                lvl = lvl - LVL_W'(1);
                            slots[SLOT_B0] = nl_slot(lvl);
                            slots[SLOT_B1] = byte_slot(c);
                        end
                        CH_COMMA:
                        begin
                            slots[SLOT_B0] = byte_slot(c);
                            slots[SLOT_B1] = nl_slot(lvl);
                        end
                        CH_COLON:
                        begin
                            slots[SLOT_B0] = byte_slot(c);
                            slots[SLOT_B1] = byte_slot(CH_SP);
                        end
                        default:
                        begin
                            slots[SLOT_B0] = byte_slot(c);
                        end
                    endcase
                end
            end

            // end of text flushes a bracket still held
            if (eot && held_next)
            begin
                slots[SLOT_C0] = byte_slot(sq_next ? CH_LBRACK : CH_LBRACE);
                if (lvl < MAX_LVL)
                    lvl = lvl + LVL_W'(1);
                slots[SLOT_C1] = nl_slot(lvl);
                held_next      = 1'b0;
            end
        end
        else
        begin
            // leaving pretty mode releases a held bracket as a bare byte
            if (held_reg)
            begin
                slots[SLOT_A0] = byte_slot(open_b);
                held_next      = 1'b0;
            end
            if (mode == MODE_PASS)
            begin
                slots[SLOT_B0] = byte_slot(c);
            end
            else if (inside_reg)
            begin
                slots[SLOT_B0] = byte_slot(c);
                if (esc_reg)
                    esc_next = 1'b0;
                else if (c == CH_BSLASH)
                    esc_next = 1'b1;
                else if (c == CH_QUOTE)
                    inside_next = 1'b0;
            end
            else if (c == CH_QUOTE)
            begin
                inside_next    = 1'b1;
                slots[SLOT_B0] = byte_slot(c);
            end
            else if (!is_ws(c))
            begin
                slots[SLOT_B0] = byte_slot(c);
            end
        end

        lvl_next = lvl;
        if (eot)
        begin
            inside_next = 1'b0;
            esc_next    = 1'b0;
            lvl_next    = '0;
            held_next   = 1'b0;
            sq_next     = 1'b0;
        end
    end

    // Handshake toward the emitter; words with no output never wait
    always_comb
    begin
        has_bytes = 1'b0;
        for (int j = 0; j < NUM_SLOTS; j++)
            has_bytes = has_bytes | slots[j].vld;
        consume    = in_full_reg && (!has_bytes || plan_ready);
        src_stall  = in_full_reg && !consume;
        plan.vld   = in_full_reg && has_bytes;
        plan.slots = slots;
    end

    // Control and formatter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            inside_reg  <= 1'b0;
            esc_reg     <= 1'b0;
            lvl_reg     <= '0;
            held_reg    <= 1'b0;
            sq_reg      <= 1'b0;
        end
        else
        begin
            if (src_valid && !src_stall)
                in_full_reg <= 1'b1;
            else if (consume)
                in_full_reg <= 1'b0;
            if (consume)
            begin
                inside_reg <= inside_next;
                esc_reg    <= esc_next;
                lvl_reg    <= lvl_next;
                held_reg   <= held_next;
                sq_reg     <= sq_next;
            end
        end
    end

    // Input word register
    always_ff @(posedge clk)
    begin
        if (src_valid && !src_stall)
            in_word_reg <= src_word;
    end

    a_lvl_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (lvl_reg <= MAX_LVL) && (lvl_reg >= MIN_LVL))
        else $error("indent level out of range");

    a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        consume && in_word_reg.end_of_text |=>
        (lvl_reg == '0) && !held_reg && !inside_reg && !esc_reg)
        else $error("end of text did not clear formatter state");

endmodule

`default_nettype wire

// ===== sv/jpp_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jpp_emit
    import jpp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire plan_t     plan,
    output      logic      plan_ready,
    output      logic      dst_valid,
    input  wire logic      dst_stall,
    output      out_word_t dst_word
);

    logic             busy_reg;
    slot_vec_t        slots_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [POS_W-1:0] pos_reg;

    slot_t            cur;
    logic             slot_end;
    logic [IDX_W:0]   nxt;
    logic [IDX_W:0]   first;
    logic             advance;
    logic             finishing;
    logic             load;

    // Current output byte from the active slot
    always_comb
    begin
        cur      = slots_reg[idx_reg];
        slot_end = !cur.is_nl || (pos_reg == {cur.cnt, 1'b1});
        nxt      = next_slot(slots_reg, idx_reg, 1'b0);
        first    = next_slot(plan.slots, '0, 1'b1);

        if (!cur.is_nl)
            dst_word.out_byte = cur.data;
        else if (pos_reg == POS_W'(0))
            dst_word.out_byte = CH_CR;
        else if (pos_reg == POS_W'(1))
            dst_word.out_byte = CH_LF;
        else
            dst_word.out_byte = CH_SP;
        dst_word.last_of_run = slot_end && !nxt[IDX_W];

        dst_valid  = busy_reg;
        advance    = busy_reg && !dst_stall;
        finishing  = advance && dst_word.last_of_run;
        plan_ready = !busy_reg || finishing;
        load       = plan_ready && plan.vld;
    end

    // Sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            pos_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= first[IDX_W-1:0];
            pos_reg  <= '0;
        end
        else if (finishing)
        begin
            busy_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (slot_end)
            begin
                idx_reg <= nxt[IDX_W-1:0];
                pos_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_reg + POS_W'(1);
            end
        end
    end

    // Plan store
    always_ff @(posedge clk)
    begin
        if (load)
            slots_reg <= plan.slots;
    end

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && dst_stall |=> busy_reg && $stable(idx_reg) && $stable(pos_reg))
        else $error("sequencer moved while output stalled");

    a_slot_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cur.vld)
        else $error("sequencer points at an empty slot");

    a_byte_slot_pos: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !cur.is_nl |-> pos_reg == '0)
        else $error("byte slot with nonzero position");

endmodule

`default_nettype wire

// ===== tb/sv/json_pretty_printer_top_tb.sv =====
`timescale 1ns / 1ps

module json_pretty_printer_top_tb;
    import jpp_pkg::*;

    localparam int NEST_MAX       = 12;
    localparam int RUN_MAX        = 60;
    localparam int IDLE_PCT       = 24;
    localparam int SETTLE_CYC     = 8;
    localparam int HOLD_CYC       = 200;
    localparam int PHASE_WORDS    = 18;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_MAX     = 10;

    // code 3 has no name in the package; it acts as compact
    localparam logic [MODE_W-1:0] MODE_COMPACT_ALT = 2'd3;

    typedef enum {ROW_CFG, ROW_MODEL, ROW_ECHO, ROW_DROP, ROW_TEXT} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic [7:0] data;
        logic       eot;
        string      txt;
    } dir_row_t;

    // DUT ports
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [MODE_W-1:0] cfg_wdata = MODE_PASS;
    logic              src_valid = 1'b0;
    logic              src_stall;
    in_word_t          src_word  = '0;
    logic              dst_valid;
    logic              dst_stall = 1'b0;
    out_word_t         dst_word;

    // formatter state mirror
    logic [MODE_W-1:0] fmt_mode  = MODE_PASS;
    bit                in_str    = 1'b0;
    bit                esc_pend  = 1'b0;
    bit                held      = 1'b0;
    bit                held_sq   = 1'b0;
    int                depth_lvl = 0;

    out_word_t step_bytes[$];
    out_word_t pending_text[$];
    dir_row_t  dir_rows[$];

    int err_cnt   = 0;
    int quiet_cyc = 0;
    int hold_left = 0;
    bit calm      = 1'b0;
    bit hold_go   = 1'b0;

    json_pretty_printer_top #(
        .MAX_DEPTH (NEST_MAX)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_word  (src_word),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_word  (dst_word)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Formatter prediction
    // ------------------------------------------------------------------
    function automatic logic is_blank(logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic void put_ch(logic [7:0] b);
        out_word_t ow;
        ow.out_byte    = b;
        ow.last_of_run = 1'b0;
        if (step_bytes.size() < RUN_MAX)
        begin
            step_bytes.insert(step_bytes.size(), ow);
        end
    endfunction

    // CR LF, then two spaces per positive level
    function automatic void line_break();
        put_ch(CH_CR);
        put_ch(CH_LF);
        for (int i = 0; i < depth_lvl; i++)
        begin
            put_ch(CH_SP);
            put_ch(CH_SP);
        end
    endfunction

    // held bracket turns out non-empty: open a block
    function automatic void open_block();
        put_ch(held_sq ? CH_LBRACK : CH_LBRACE);
        if (depth_lvl < NEST_MAX)
        begin
            depth_lvl++;
        end
        line_break();
        held = 1'b0;
    endfunction

    function automatic void scan_string(logic [7:0] c);
        if (esc_pend)
        begin
            esc_pend = 1'b0;
        end
        else if (c == CH_BSLASH)
        begin
            esc_pend = 1'b1;
        end
        else if (c == CH_QUOTE)
        begin
            in_str = 1'b0;
        end
    endfunction

    function automatic void pretty_ch(logic [7:0] c);
        logic [7:0] closer;
        if (in_str)
        begin
            put_ch(c);
            scan_string(c);
            return;
        end
        if (is_blank(c))
        begin
            return;
        end
        if (held)
        begin
            closer = held_sq ? CH_RBRACK : CH_RBRACE;
            if (c == closer)
            begin
                put_ch(held_sq ? CH_LBRACK : CH_LBRACE);
                put_ch(c);
                held = 1'b0;
                return;
            end
            open_block();
        end
        if (c == CH_QUOTE)
        begin
            in_str = 1'b1;
            put_ch(c);
        end
        else if (c == CH_LBRACE || c == CH_LBRACK)
        begin
            held    = 1'b1;
            held_sq = (c == CH_LBRACK);
        end
        else if (c == CH_RBRACE || c == CH_RBRACK)
        begin
            if (depth_lvl > -NEST_MAX)
            begin
                depth_lvl--;
            end
            line_break();
            put_ch(c);
        end
        else if (c == CH_COMMA)
        begin
            put_ch(c);
            line_break();
        end
        else if (c == CH_COLON)
        begin
            put_ch(c);
            put_ch(CH_SP);
        end
        else
        begin
            put_ch(c);
        end
    endfunction

    // Output bytes caused by one input word, left in step_bytes
    function automatic void format_byte(in_word_t w);
        logic [7:0] c;
        c = w.in_byte;
        step_bytes.delete();
        if (fmt_mode == MODE_PRETTY)
        begin
            pretty_ch(c);
            if (w.end_of_text && held)
            begin
                open_block();
            end
        end
        else
        begin
            // leaving pretty mode releases a held bracket as a bare byte
            if (held)
            begin
                put_ch(held_sq ? CH_LBRACK : CH_LBRACE);
                held = 1'b0;
            end
            if (fmt_mode == MODE_PASS)
            begin
                put_ch(c);
            end
            else if (in_str)
            begin
                put_ch(c);
                scan_string(c);
            end
            else if (c == CH_QUOTE)
            begin
                in_str = 1'b1;
                put_ch(c);
            end
            else if (!is_blank(c))
            begin
                put_ch(c);
            end
        end
        if (w.end_of_text)
        begin
            in_str    = 1'b0;
            esc_pend  = 1'b0;
            depth_lvl = 0;
            held      = 1'b0;
            held_sq   = 1'b0;
        end
        if (step_bytes.size() > 0)
        begin
            step_bytes[step_bytes.size() - 1].last_of_run = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Random JSON text
    // ------------------------------------------------------------------
    function automatic void add_blank(ref logic [7:0] q[$]);
        int n;
        if ($urandom_range(0, 99) < 25)
        begin
            n = $urandom_range(1, 2);
            repeat (n)
            begin
                case ($urandom_range(0, 3))
                    0: q.insert(q.size(), CH_SP);
                    1: q.insert(q.size(), CH_TAB);
                    2: q.insert(q.size(), CH_CR);
                    default: q.insert(q.size(), CH_LF);
                endcase
            end
        end
    endfunction

    function automatic void add_string(ref logic [7:0] q[$], input int max_len);
        string      punct;
        logic [7:0] c;
        int         n;
        int         r;
        punct = "{}[],: \t";
        n = $urandom_range(0, max_len);
        q.insert(q.size(), CH_QUOTE);
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                q.insert(q.size(), CH_BSLASH);
                c = $urandom_range(0, 1) ? CH_QUOTE : 8'($urandom_range(32, 126));
                q.insert(q.size(), c);
            end
            else if (r < 35)
            begin
                q.insert(q.size(), punct[$urandom_range(0, punct.len() - 1)]);
            end
            else if (r < 50)
            begin
                q.insert(q.size(), 8'($urandom_range(128, 255)));
            end
            else
            begin
                c = 8'($urandom_range(32, 126));
                if (c == CH_QUOTE || c == CH_BSLASH)
                begin
                    c = "a";
                end
                q.insert(q.size(), c);
            end
        end
        q.insert(q.size(), CH_QUOTE);
    endfunction

    function automatic void add_scalar(ref logic [7:0] q[$]);
        string word;
        int    n;
        case ($urandom_range(0, 2))
            0:
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    q.insert(q.size(), "-");
                end
                n = $urandom_range(1, 3);
                repeat (n) q.insert(q.size(), 8'("0" + $urandom_range(0, 9)));
            end
            1:
            begin
                word = $urandom_range(0, 1) ? "true" : "null";
                for (int i = 0; i < word.len(); i++) q.insert(q.size(), word[i]);
            end
            default: add_string(q, 5);
        endcase
    endfunction

    // One well-formed value; chain nests one member per level up to max_nest
    function automatic void gen_json(ref logic [7:0] q[$], input int max_nest, input bit chain);
        bit box_sq[$];
        int box_left[$];
        int box_done[$];
        bit need_val;
        bit sq;
        int top;
        need_val = 1'b1;
        while (need_val)
        begin
            add_blank(q);
            if (box_sq.size() < max_nest && (chain || $urandom_range(0, 99) < 40))
            begin
                sq = chain ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 1) != 0);
                box_sq.insert(box_sq.size(), sq);
                q.insert(q.size(), sq ? CH_LBRACK : CH_LBRACE);
                box_left.insert(box_left.size(), chain ? 1 : $urandom_range(0, 3));
                box_done.insert(box_done.size(), 0);
            end
            else
            begin
                add_scalar(q);
            end
            need_val = 1'b0;
            while (box_sq.size() > 0 && !need_val)
            begin
                top = box_sq.size() - 1;
                if (box_left[top] == 0)
                begin
                    add_blank(q);
                    q.insert(q.size(), box_sq[top] ? CH_RBRACK : CH_RBRACE);
                    box_sq.delete(top);
                    box_left.delete(top);
                    box_done.delete(top);
                end
                else
                begin
                    if (box_done[top] > 0)
                    begin
                        q.insert(q.size(), CH_COMMA);
                    end
                    if (!box_sq[top])
                    begin
                        add_blank(q);
                        add_string(q, chain ? 2 : 5);
                        add_blank(q);
                        q.insert(q.size(), CH_COLON);
                    end
                    box_left[top] = box_left[top] - 1;
                    box_done[top] = box_done[top] + 1;
                    need_val = 1'b1;
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Directed rows
    // ------------------------------------------------------------------
    function automatic void add_row(row_kind_t kind, logic [7:0] data, logic eot, string txt);
        dir_row_t row;
        row.kind = kind;
        row.data = data;
        row.eot  = eot;
        row.txt  = txt;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void load_directed();
        // passthrough straight out of reset
        add_row(ROW_ECHO,  8'h00,     1'b0, "");
        add_row(ROW_ECHO,  8'hFF,     1'b0, "");
        add_row(ROW_ECHO,  CH_LBRACE, 1'b0, "");
        add_row(ROW_ECHO,  CH_QUOTE,  1'b1, "");
        // compact: blanks dropped outside strings, kept inside, escapes honored
        add_row(ROW_CFG,   8'(MODE_COMPACT), 1'b0, "");
        add_row(ROW_DROP,  CH_SP,     1'b0, "");
        add_row(ROW_ECHO,  CH_QUOTE,  1'b0, "");
        add_row(ROW_ECHO,  CH_TAB,    1'b0, "");
        add_row(ROW_ECHO,  CH_BSLASH, 1'b0, "");
        add_row(ROW_ECHO,  CH_QUOTE,  1'b0, "");
        add_row(ROW_ECHO,  CH_QUOTE,  1'b0, "");
        add_row(ROW_DROP,  CH_LF,     1'b0, "");
        add_row(ROW_ECHO,  8'hFF,     1'b1, "");
        // pretty: empty pair, colon, mismatched close, negative level, flush at end
        add_row(ROW_CFG,   8'(MODE_PRETTY), 1'b0, "");
        add_row(ROW_DROP,  CH_LBRACK, 1'b0, "");
        add_row(ROW_TEXT,  CH_RBRACK, 1'b0, "[]");
        add_row(ROW_TEXT,  CH_COLON,  1'b0, ": ");
        add_row(ROW_DROP,  CH_LBRACE, 1'b0, "");
        add_row(ROW_MODEL, CH_RBRACK, 1'b0, "");
        add_row(ROW_MODEL, CH_COMMA,  1'b0, "");
        add_row(ROW_MODEL, CH_RBRACE, 1'b0, "");
        add_row(ROW_MODEL, CH_LBRACK, 1'b1, "");
        add_row(ROW_DROP,  CH_LBRACE, 1'b0, "");
        // mode change while a bracket is held
        add_row(ROW_CFG,   8'(MODE_COMPACT_ALT), 1'b0, "");
        add_row(ROW_TEXT,  CH_COMMA,  1'b0, "{,");
        add_row(ROW_DROP,  CH_CR,     1'b1, "");
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    task automatic send_word(in_word_t w, row_kind_t kind, string txt);
        out_word_t ow;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_word  <= w;
        do @(posedge clk); while (src_stall);
        format_byte(w);
        case (kind)
            ROW_ECHO:
            begin
                ow.out_byte    = w.in_byte;
                ow.last_of_run = 1'b1;
                pending_text.insert(pending_text.size(), ow);
            end
            ROW_TEXT:
            begin
                for (int i = 0; i < txt.len(); i++)
                begin
                    ow.out_byte    = txt[i];
                    ow.last_of_run = (i == txt.len() - 1);
                    pending_text.insert(pending_text.size(), ow);
                end
            end
            ROW_DROP: ;
            default:
            begin
                foreach (step_bytes[i]) pending_text.insert(pending_text.size(), step_bytes[i]);
            end
        endcase
    endtask

    // drain: nothing expected, then let trailing work finish
    task automatic settle();
        src_valid <= 1'b0;
        while (pending_text.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic cfg_write(logic [MODE_W-1:0] m);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we   <= 1'b0;
        fmt_mode  = m;
    endtask

    task automatic run_phase(logic [MODE_W-1:0] m);
        logic [7:0] q[$];
        in_word_t   w;
        bit         eot_last;
        int         sent;
        int         n;
        int         r;
        cfg_write(m);
        sent = 0;
        while (sent < PHASE_WORDS)
        begin
            q.delete();
            eot_last = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                gen_json(q, $urandom_range(1, 4), 1'b0);
                eot_last = ($urandom_range(0, 9) != 0);
            end
            else if (r < 78)
            begin
                gen_json(q, $urandom_range(NEST_MAX + 1, NEST_MAX + 4), 1'b1);
            end
            else if (r < 88)
            begin
                // stray closers drive the level negative
                n = $urandom_range(1, NEST_MAX + 2);
                repeat (n)
                begin
                    add_blank(q);
                    q.insert(q.size(), $urandom_range(0, 1) ? CH_RBRACK : CH_RBRACE);
                end
                eot_last = ($urandom_range(0, 3) == 0);
            end
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n) q.insert(q.size(), 8'($urandom_range(0, 255)));
                eot_last = ($urandom_range(0, 1) != 0);
            end
            foreach (q[i])
            begin
                w.in_byte     = q[i];
                w.end_of_text = (i == q.size() - 1) && eot_last;
                send_word(w, ROW_MODEL, "");
            end
            sent += q.size();
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side: check each word, then pick next stall
    // ------------------------------------------------------------------
    task automatic log_fault(string what, out_word_t want, out_word_t got);
        err_cnt++;
        if (err_cnt <= REPORT_MAX)
        begin
            $display("%s: expected byte %h last %b, got byte %h last %b",
                     what, want.out_byte, want.last_of_run, got.out_byte, got.last_of_run);
        end
    endtask

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n)
        begin
            if (dst_valid && !dst_stall)
            begin
                if (pending_text.size() == 0)
                begin
                    want = '0;
                    log_fault("output word with nothing pending", want, dst_word);
                end
                else
                begin
                    want = pending_text.pop_front();
                    if (dst_word.out_byte !== want.out_byte ||
                        dst_word.last_of_run !== want.last_of_run)
                    begin
                        log_fault("output mismatch", want, dst_word);
                    end
                end
            end
            if (hold_go)
            begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYC;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                dst_stall <= 1'b1;
            end
            else
            begin
                dst_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Watchdog: cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (src_valid && !src_stall) || (dst_valid && !dst_stall))
        begin
            quiet_cyc = 0;
        end
        else
        begin
            quiet_cyc++;
        end
        if (quiet_cyc >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        in_word_t          w;
        logic [MODE_W-1:0] modes [7];
        modes = '{MODE_PRETTY, MODE_COMPACT, MODE_PRETTY, MODE_PASS,
                  MODE_COMPACT_ALT, MODE_PRETTY, MODE_PASS};
        modes[6] = MODE_W'($urandom_range(0, 3));
        load_directed();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                cfg_write(dir_rows[i].data[MODE_W-1:0]);
            end
            else
            begin
                w.in_byte     = dir_rows[i].data;
                w.end_of_text = dir_rows[i].eot;
                send_word(w, dir_rows[i].kind, dir_rows[i].txt);
            end
        end

        // first phase runs without idling, third one holds the output off
        foreach (modes[p])
        begin
            calm = (p == 0);
            if (p == 2)
            begin
                hold_go = 1'b1;
            end
            run_phase(modes[p]);
        end
        calm = 1'b0;
        settle();

        if (err_cnt == 0 && pending_text.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
